// ----- hw/rtl/apfp_pkg.sv -----
// ----------------------------------------------------------------------------
// ARGB pixel format packer package
// Format codes, pixel field helpers and the packer result type.
// ----------------------------------------------------------------------------
package apfp_pkg;

    // Output format codes as held in the configuration register.
    typedef enum logic [2:0] {
        FMT_ARGB32     = 3'd0,
        FMT_BGR24      = 3'd1,
        FMT_RGB565     = 3'd2,
        FMT_RGB555     = 3'd3,
        FMT_RGB565_SW  = 3'd4,
        FMT_RGB555_SW  = 3'd5,
        FMT_BGRA32     = 3'd6
    } t_format;

    // Group phase codes used by the three-word BGR24 group.
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;
    localparam logic [1:0] PHASE_3 = 2'd3;

    // Colour field masks within an ARGB pixel.
    localparam logic [31:0] MASK_R5 = 32'h00f8_0000;
    localparam logic [31:0] MASK_G6 = 32'h0000_fc00;
    localparam logic [31:0] MASK_G5 = 32'h0000_f800;
    localparam logic [31:0] MASK_B5 = 32'h0000_00f8;
    localparam logic [31:0] MASK_B8 = 32'h0000_00ff;
    localparam logic [31:0] MASK_G8 = 32'h0000_ff00;
    localparam logic [31:0] MASK_R8 = 32'h00ff_0000;

    // Outcome of packing one pixel: the next state and an optional word.
    typedef struct packed {
        logic        emit;
        logic [31:0] word;
        logic [1:0]  phase;
        logic [31:0] partial;
    } t_pack_result;

    // Reverses the four bytes of a word.
    function automatic logic [31:0] byte_reverse(input logic [31:0] v);
        byte_reverse = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Reduces an ARGB pixel to RGB565.
    function automatic logic [15:0] to565(input logic [31:0] p);
        logic [31:0] t;
        t = ((p & MASK_R5) >> 8) | ((p & MASK_G6) >> 5) | ((p & MASK_B5) >> 3);
        to565 = t[15:0];
    endfunction

    // Reduces an ARGB pixel to RGB555.
    function automatic logic [15:0] to555(input logic [31:0] p);
        logic [31:0] t;
        t = ((p & MASK_R5) >> 9) | ((p & MASK_G5) >> 6) | ((p & MASK_B5) >> 3);
        to555 = t[15:0];
    endfunction

endpackage

// ----- hw/rtl/apfp_pack_core.sv -----
// ----------------------------------------------------------------------------
// ARGB pixel format packer core
// Combinational packing of one pixel against the current group state.
// ----------------------------------------------------------------------------
module apfp_pack_core (
    input  apfp_pkg::t_format      i_format,
    input  logic [1:0]             i_phase,
    input  logic [31:0]            i_partial,
    input  logic [31:0]            i_pixel,
    input  logic                   i_row_end,
    output apfp_pkg::t_pack_result o_result
);
    import apfp_pkg::*;

    logic [7:0]   w_b;
    logic [7:0]   w_g;
    logic [7:0]   w_r;
    logic [15:0]  w_half;
    logic         w_swapped;
    t_pack_result w_res;

    assign w_b = i_pixel[7:0];
    assign w_g = i_pixel[15:8];
    assign w_r = i_pixel[23:16];

    // Half-word pixel and lane order for the 16-bit formats.
    assign w_half    = (i_format == FMT_RGB565 || i_format == FMT_RGB565_SW)
                       ? to565(i_pixel) : to555(i_pixel);
    assign w_swapped = (i_format == FMT_RGB565_SW || i_format == FMT_RGB555_SW);

    // Format selection and group sequencing.
    always_comb begin
        w_res.emit    = 1'b0;
        w_res.word    = 32'h0;
        w_res.phase   = PHASE_0;
        w_res.partial = 32'h0;
        case (i_format)
            FMT_BGR24: begin
                case (i_phase)
                    PHASE_0: begin
                        w_res.partial = {w_b, w_g, w_r, 8'h00};
                        w_res.phase   = PHASE_1;
                    end
                    PHASE_1: begin
                        w_res.emit    = 1'b1;
                        w_res.word    = i_partial | {24'h0, w_b};
                        w_res.partial = {w_g, w_r, 16'h0};
                        w_res.phase   = PHASE_2;
                    end
                    PHASE_2: begin
                        w_res.emit    = 1'b1;
                        w_res.word    = i_partial | {16'h0, w_b, w_g};
                        w_res.partial = {w_r, 24'h0};
                        w_res.phase   = PHASE_3;
                    end
                    default: begin
                        w_res.emit = 1'b1;
                        w_res.word = i_partial | {8'h0, w_b, w_g, w_r};
                    end
                endcase
            end
            FMT_RGB565, FMT_RGB555, FMT_RGB565_SW, FMT_RGB555_SW: begin
                if (i_phase == PHASE_0) begin
                    w_res.partial = w_swapped ? {16'h0, w_half} : {w_half, 16'h0};
                    w_res.phase   = PHASE_1;
                end else begin
                    w_res.emit = 1'b1;
                    w_res.word = w_swapped ? byte_reverse(i_partial | {w_half, 16'h0})
                                           : (i_partial | {16'h0, w_half});
                end
            end
            FMT_BGRA32: begin
                w_res.emit = 1'b1;
                w_res.word = byte_reverse(i_pixel);
            end
            default: begin
                w_res.emit = 1'b1;
                w_res.word = i_pixel;
            end
        endcase

        // The end of a row drops any word still being gathered.
        if (i_row_end) begin
            w_res.phase   = PHASE_0;
            w_res.partial = 32'h0;
        end
    end

    assign o_result = w_res;

endmodule

// ----- hw/rtl/argb_pixel_format_packer.sv -----
// ----------------------------------------------------------------------------
// ARGB pixel format packer
// Packs a stream of ARGB8888 pixels into 32-bit words of the chosen format.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_ready carry one pixel request with
//   i_pixel and i_row_end. Output channel: o_out_valid / i_out_ready carry
//   one packed word on o_out_word.
//   Configuration: i_cfg_wr_en with i_cfg_wr_data selects the output format
//   and restarts the pixel group; write it only while the block is idle.
//   A completed word is registered in the output or skid register.
//   Throughput: one pixel per cycle while o_in_ready is high, set by the
//   single combinational packing stage between the group state and the
//   output register. argb32 and bgra32 give a word per pixel, the 16-bit
//   formats one word per two pixels, bgr24 three words per four pixels.
//   Reset: the format returns to argb32 and the group state and both output
//   registers are emptied in the same cycle.
//   Stall: a second output register catches one word while the receiver
//   stalls; o_in_ready falls only once that register is full.
//   A row end drops a partly gathered word and restarts the group.
// ----------------------------------------------------------------------------
module argb_pixel_format_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_pixel,
    input  logic        i_row_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_word
);
    import apfp_pkg::*;

    t_format      r_format;
    logic [1:0]   r_phase;
    logic [31:0]  r_partial;
    logic         r_out_valid;
    logic [31:0]  r_out_word;
    logic         r_skid_valid;
    logic [31:0]  r_skid_word;
    t_pack_result w_res;
    logic         w_accept;
    logic         w_push;
    logic         w_take;

    // Packing logic for the current pixel.
    apfp_pack_core u_core (
        .i_format  (r_format),
        .i_phase   (r_phase),
        .i_partial (r_partial),
        .i_pixel   (i_pixel),
        .i_row_end (i_row_end),
        .o_result  (w_res)
    );

    assign o_in_ready = !r_skid_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_push     = w_accept && w_res.emit;
    assign w_take     = r_out_valid && i_out_ready;

    // Format register and group state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format  <= FMT_ARGB32;
            r_phase   <= PHASE_0;
            r_partial <= 32'h0;
        end else if (i_cfg_wr_en) begin
            r_format  <= t_format'(i_cfg_wr_data);
            r_phase   <= PHASE_0;
            r_partial <= 32'h0;
        end else if (w_accept) begin
            r_phase   <= w_res.phase;
            r_partial <= w_res.partial;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_out_word   <= r_skid_word;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
                r_out_word  <= w_res.word;
            end
        end else if (!r_out_valid) begin
            r_out_valid <= w_push;
            r_out_word  <= w_res.word;
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
            r_skid_word  <= w_res.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTH
    // The skid register is only ever filled behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // A word is caught in the skid register only while the output stalls.
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid register filled without an output stall");

    // The two-pixel formats never leave the first two phases.
    a_half_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_format == FMT_RGB565 || r_format == FMT_RGB555 ||
         r_format == FMT_RGB565_SW || r_format == FMT_RGB555_SW)
        |-> (r_phase == PHASE_0 || r_phase == PHASE_1))
        else $error("16-bit format reached a bgr24 phase");

    // One word per pixel formats keep no group state.
    a_single_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_format == FMT_BGR24 || r_format == FMT_RGB565 || r_format == FMT_RGB555 ||
          r_format == FMT_RGB565_SW || r_format == FMT_RGB555_SW)
        |-> (r_phase == PHASE_0 && r_partial == 32'h0))
        else $error("group state held in a one word per pixel format");
`endif

endmodule
